// ===== sv/sitda_pkg.sv =====
// Shared types, constants and the double-dabble step for the integer-to-decimal converter.
package sitda_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned NumDigits     = 10;
  localparam int unsigned BcdW          = NumDigits * DigitW;
  localparam int unsigned CharW         = 8;
  localparam int unsigned PosW          = $clog2(NumDigits);
  localparam int unsigned StepsPerStage = 8;
  localparam int unsigned NumDdStages   = ValueW / StepsPerStage;

  localparam logic [CharW-1:0] AsciiZero  = 8'd48;
  localparam logic [CharW-1:0] AsciiMinus = 8'd45;

  // One item in flight: sign, BCD accumulator and the magnitude bits still to shift in.
  typedef struct packed {
    logic              neg;
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } pipe_t;

  // One shift-and-add-3 step of the binary-to-BCD conversion.
  function automatic pipe_t dd_step(input pipe_t cur);
    pipe_t           nxt;
    logic [BcdW-1:0] adj;
    nxt = cur;
    adj = cur.bcd;
    for (int d = 0; d < NumDigits; d++) begin
      if (cur.bcd[d*DigitW +: DigitW] >= 4'd5) begin
        adj[d*DigitW +: DigitW] = cur.bcd[d*DigitW +: DigitW] + 4'd3;
      end
    end
    nxt.bcd = {adj[BcdW-2:0], cur.bin[ValueW-1]};
    nxt.bin = {cur.bin[ValueW-2:0], 1'b0};
    return nxt;
  endfunction

endpackage

// ===== sv/sitda_dd_stage.sv =====
// One registered pipeline stage that runs a group of double-dabble steps.
module sitda_dd_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sitda_pkg::pipe_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sitda_pkg::pipe_t out_data_o
);
  import sitda_pkg::*;

  logic  valid_q, valid_d;
  pipe_t data_q, data_d;
  pipe_t work;

  // Chain of shift-and-add-3 steps for this stage.
  always_comb begin
    work = in_data_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      work = dd_step(work);
    end
  end

  // The stage takes a new transaction when empty or when its content moves on.
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        data_d = work;
      end
    end
  end

  // Valid bit is control state; the payload register needs no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== sv/sitda_serializer.sv =====
// Output stage that sends the sign and the significant BCD digits one character at a time.
module sitda_serializer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sitda_pkg::pipe_t              in_data_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [sitda_pkg::CharW-1:0]   m_axis_tdata_o,
  output logic                          m_axis_tlast_o
);
  import sitda_pkg::*;

  logic              busy_q, busy_d;
  logic              neg_q, neg_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [BcdW-1:0]   bcd_q, bcd_d;
  logic [PosW-1:0]   top_digit;
  logic [DigitW-1:0] cur_digit;
  logic              out_fire;
  logic              load;

  // Highest nonzero digit of the incoming value; zero leaves a single digit.
  always_comb begin
    top_digit = '0;
    for (int d = 0; d < NumDigits; d++) begin
      if (in_data_i.bcd[d*DigitW +: DigitW] != '0) begin
        top_digit = PosW'(d);
      end
    end
  end

  // Character presented from the held digits.
  assign cur_digit       = bcd_q[DigitW*pos_q +: DigitW];
  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = neg_q ? AsciiMinus : (AsciiZero + {{(CharW-DigitW){1'b0}}, cur_digit});
  assign m_axis_tlast_o  = !neg_q && (pos_q == '0);

  assign out_fire   = m_axis_tvalid_o && m_axis_tready_i;
  assign in_ready_o = !busy_q || (out_fire && m_axis_tlast_o);
  assign load       = in_valid_i && in_ready_o;

  // Walk from the sign through the digits down to the units digit.
  always_comb begin
    busy_d = busy_q;
    neg_d  = neg_q;
    pos_d  = pos_q;
    bcd_d  = bcd_q;
    if (out_fire) begin
      if (neg_q) begin
        neg_d = 1'b0;
      end else if (pos_q == '0) begin
        busy_d = 1'b0;
      end else begin
        pos_d = pos_q - 1'b1;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      neg_d  = in_data_i.neg;
      pos_d  = top_digit;
      bcd_d  = in_data_i.bcd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      neg_q  <= 1'b0;
      pos_q  <= '0;
    end else begin
      busy_q <= busy_d;
      neg_q  <= neg_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  // The digit position never leaves the ten-digit window.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosW'(NumDigits))
    else $error("digit position out of range");

  // A pending sign only exists while a run is being sent.
  a_neg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    neg_q |-> busy_q)
    else $error("sign pending without an active run");

  // A run does not end before its flagged last character.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !m_axis_tlast_o) |=> busy_q)
    else $error("run ended before its last character");

  // Digit characters stay within '0' to '9'.
  a_digit_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !neg_q) |-> (cur_digit <= 4'd9))
    else $error("held digit is not decimal");

endmodule

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Each input transaction carries one signed 32-bit value; the block answers with
// its decimal text, most significant character first, one character per output
// transaction, with tlast on the final character. Negative values start with '-',
// leading zeros are dropped and zero gives a single '0', so a run is 1 to 11
// characters long. The value passes a sign/magnitude stage and four double-dabble
// stages of eight steps each, then enters the character serializer. The serializer
// sends one character per cycle while m_axis_tready_i is high and takes the next
// value in the cycle of the current run's last character; the pipeline stages in
// front keep up to five further values in flight. Nothing is kept between values.
module signed_int_to_decimal_ascii (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic signed [sitda_pkg::ValueW-1:0] s_axis_tdata_i,  // [31:0] value
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [sitda_pkg::CharW-1:0]        m_axis_tdata_o,   // [7:0] character
  output logic                               m_axis_tlast_o    // last
);
  import sitda_pkg::*;

  logic  s0_valid_q, s0_valid_d;
  pipe_t s0_data_q, s0_data_d;
  logic  [ValueW-1:0] raw;

  logic  dd_valid [NumDdStages+1];
  logic  dd_ready [NumDdStages+1];
  pipe_t dd_data  [NumDdStages+1];

  // Sign and magnitude stage; the magnitude is unsigned so the most negative value works.
  assign raw             = ValueW'(s_axis_tdata_i);
  assign s_axis_tready_o = !s0_valid_q || dd_ready[0];

  always_comb begin
    s0_valid_d = s0_valid_q;
    s0_data_d  = s0_data_q;
    if (s_axis_tready_o) begin
      s0_valid_d = s_axis_tvalid_i;
      if (s_axis_tvalid_i) begin
        s0_data_d.neg = raw[ValueW-1];
        s0_data_d.bcd = '0;
        s0_data_d.bin = raw[ValueW-1] ? (~raw + 1'b1) : raw;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_data_q <= s0_data_d;
  end

  assign dd_valid[0] = s0_valid_q;
  assign dd_data[0]  = s0_data_q;

  // Binary-to-BCD conversion pipeline.
  for (genvar g = 0; g < NumDdStages; g++) begin : g_dd
    sitda_dd_stage u_dd (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dd_valid[g]),
      .in_ready_o  (dd_ready[g]),
      .in_data_i   (dd_data[g]),
      .out_valid_o (dd_valid[g+1]),
      .out_ready_i (dd_ready[g+1]),
      .out_data_o  (dd_data[g+1])
    );
  end

  // Character output.
  sitda_serializer u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (dd_valid[NumDdStages]),
    .in_ready_o      (dd_ready[NumDdStages]),
    .in_data_i       (dd_data[NumDdStages]),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
